[rtl/dsf_pkg.sv]
// Shared types and constants for the divisor-sum block.
// Holds widths, the datapath operation codes and the controller/datapath structs.
// Used by dsf_ctrl, dsf_datapath and the top level; depends on nothing.
package dsf_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int CAND_WIDTH    = VALUE_WIDTH / 2 + 1;
  localparam int SUM_WIDTH     = 35;
  localparam int PSUM_WIDTH    = VALUE_WIDTH + 2;
  localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TERM_MUL,
    OP_SUM_ADD,
    OP_NEXT_CAND,
    OP_MUL_PSUM,
    OP_MUL_FINAL,
    OP_MUL_STEP,
    OP_MUL_STORE,
    OP_PUBLISH
  } dsf_op_t;

  typedef struct packed {
    dsf_op_t op;
  } dsf_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quot_lt_cand;
    logic rem_zero;
    logic psum_one;
    logic remaining_ge2;
    logic mul_done;
    logic out_free;
  } dsf_status_t;

endpackage

[rtl/dsf_ctrl.sv]
// Controller state machine for the divisor-sum block.
// Sequences trial division, prime-power accumulation and the shift-add multiplies.
// Depends on dsf_pkg; drives dsf_datapath through dsf_cmd_t.
module dsf_ctrl import dsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dsf_status_t status,
  output dsf_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_EVAL,
    ST_SUM_ADD,
    ST_NEXT_CAND,
    ST_MUL_RUN,
    ST_FIN_CHECK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   outer_r, outer_nxt;   // next division result also decides the outer loop
  logic   final_r, final_nxt;   // multiply in flight is the closing cofactor multiply

  always_comb begin
    state_nxt = state_r;
    outer_nxt = outer_r;
    final_nxt = final_r;
    cmd.op    = OP_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          outer_nxt = 1'b1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (outer_r && status.quot_lt_cand) begin
          state_nxt = ST_FIN_CHECK;
        end else if (status.rem_zero) begin
          // candidate divides: strip it and extend the power sum
          cmd.op    = OP_TERM_MUL;
          outer_nxt = 1'b0;
          state_nxt = ST_SUM_ADD;
        end else if (status.psum_one) begin
          state_nxt = ST_NEXT_CAND;
        end else begin
          cmd.op    = OP_MUL_PSUM;
          final_nxt = 1'b0;
          state_nxt = ST_MUL_RUN;
        end
      end
      ST_SUM_ADD: begin
        cmd.op    = OP_SUM_ADD;
        state_nxt = ST_DIV_INIT;
      end
      ST_NEXT_CAND: begin
        cmd.op    = OP_NEXT_CAND;
        outer_nxt = 1'b1;
        state_nxt = ST_DIV_INIT;
      end
      ST_MUL_RUN: begin
        if (status.mul_done) begin
          cmd.op    = OP_MUL_STORE;
          state_nxt = final_r ? ST_DONE : ST_NEXT_CAND;
        end else begin
          cmd.op = OP_MUL_STEP;
        end
      end
      ST_FIN_CHECK: begin
        if (status.remaining_ge2) begin
          cmd.op    = OP_MUL_FINAL;
          final_nxt = 1'b1;
          state_nxt = ST_MUL_RUN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op    = OP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outer_r <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outer_r <= outer_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

[rtl/dsf_datapath.sv]
// Datapath of the divisor-sum block: factor registers, a bit-serial restoring
// divider, a shift-add multiplier and the output register.
// Depends on dsf_pkg; commanded by dsf_ctrl.
module dsf_datapath import dsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dsf_cmd_t               cmd,
  output dsf_status_t            status,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_WIDTH-1:0]   out_divisor_sum
);

  logic [VALUE_WIDTH-1:0]   remaining_r, remaining_nxt;
  logic [CAND_WIDTH-1:0]    candidate_r, candidate_nxt;
  logic [SUM_WIDTH-1:0]     product_r, product_nxt;
  logic [PSUM_WIDTH-1:0]    power_sum_r, power_sum_nxt;
  logic [VALUE_WIDTH-1:0]   power_term_r, power_term_nxt;
  logic [VALUE_WIDTH-1:0]   dvd_r, dvd_nxt;        // dividend in, quotient out
  logic [CAND_WIDTH-1:0]    part_rem_r, part_rem_nxt;
  logic [DIV_CNT_WIDTH-1:0] div_cnt_r, div_cnt_nxt;
  logic [SUM_WIDTH-1:0]     mul_a_r, mul_a_nxt;
  logic [PSUM_WIDTH-1:0]    mul_b_r, mul_b_nxt;
  logic [SUM_WIDTH-1:0]     mul_acc_r, mul_acc_nxt;
  logic [SUM_WIDTH-1:0]     out_sum_r, out_sum_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [CAND_WIDTH:0]             trial;
  logic                            trial_ge;
  logic [VALUE_WIDTH+CAND_WIDTH-1:0] term_prod;
  logic                            publish;

  // one restoring-division step: bring down the next dividend bit
  assign trial     = {part_rem_r, dvd_r[VALUE_WIDTH-1]};
  assign trial_ge  = (trial >= {1'b0, candidate_r});
  assign term_prod = power_term_r * candidate_r;
  assign publish   = (cmd.op == OP_PUBLISH);

  always_comb begin
    remaining_nxt  = remaining_r;
    candidate_nxt  = candidate_r;
    product_nxt    = product_r;
    power_sum_nxt  = power_sum_r;
    power_term_nxt = power_term_r;
    dvd_nxt        = dvd_r;
    part_rem_nxt   = part_rem_r;
    div_cnt_nxt    = div_cnt_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    mul_acc_nxt    = mul_acc_r;
    out_sum_nxt    = out_sum_r;
    unique case (cmd.op)
      OP_IDLE: ;
      OP_LOAD: begin
        remaining_nxt  = in_value;
        candidate_nxt  = CAND_WIDTH'(2);
        product_nxt    = SUM_WIDTH'(1);
        power_sum_nxt  = PSUM_WIDTH'(1);
        power_term_nxt = VALUE_WIDTH'(1);
      end
      OP_DIV_INIT: begin
        dvd_nxt      = remaining_r;
        part_rem_nxt = '0;
        div_cnt_nxt  = '0;
      end
      OP_DIV_STEP: begin
        part_rem_nxt = trial_ge ? CAND_WIDTH'(trial - {1'b0, candidate_r})
                                : trial[CAND_WIDTH-1:0];
        dvd_nxt      = {dvd_r[VALUE_WIDTH-2:0], trial_ge};
        div_cnt_nxt  = div_cnt_r + 1'b1;
      end
      OP_TERM_MUL: begin
        remaining_nxt  = dvd_r;
        power_term_nxt = term_prod[VALUE_WIDTH-1:0];
      end
      OP_SUM_ADD: begin
        power_sum_nxt = power_sum_r + PSUM_WIDTH'(power_term_r);
      end
      OP_NEXT_CAND: begin
        candidate_nxt  = candidate_r + 1'b1;
        power_sum_nxt  = PSUM_WIDTH'(1);
        power_term_nxt = VALUE_WIDTH'(1);
      end
      OP_MUL_PSUM: begin
        mul_a_nxt   = product_r;
        mul_b_nxt   = power_sum_r;
        mul_acc_nxt = '0;
      end
      OP_MUL_FINAL: begin
        mul_a_nxt   = product_r;
        mul_b_nxt   = PSUM_WIDTH'(remaining_r) + PSUM_WIDTH'(1);
        mul_acc_nxt = '0;
      end
      OP_MUL_STEP: begin
        if (mul_b_r[0]) begin
          mul_acc_nxt = mul_acc_r + mul_a_r;
        end
        mul_a_nxt = {mul_a_r[SUM_WIDTH-2:0], 1'b0};
        mul_b_nxt = {1'b0, mul_b_r[PSUM_WIDTH-1:1]};
      end
      OP_MUL_STORE: begin
        product_nxt = mul_acc_r;
      end
      OP_PUBLISH: begin
        out_sum_nxt = product_r;
      end
      default: ;
    endcase
  end

  // hold a waiting result; drop it once taken
  assign out_valid_nxt = publish | (out_valid_r & out_stall);

  always_comb begin
    status.div_last      = (div_cnt_r == DIV_CNT_WIDTH'(VALUE_WIDTH - 1));
    status.quot_lt_cand  = (dvd_r < VALUE_WIDTH'(candidate_r));
    status.rem_zero      = (part_rem_r == '0);
    status.psum_one      = (power_sum_r == PSUM_WIDTH'(1));
    status.remaining_ge2 = |remaining_r[VALUE_WIDTH-1:1];
    status.mul_done      = (mul_b_r == '0);
    status.out_free      = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    remaining_r  <= remaining_nxt;
    candidate_r  <= candidate_nxt;
    product_r    <= product_nxt;
    power_sum_r  <= power_sum_nxt;
    power_term_r <= power_term_nxt;
    dvd_r        <= dvd_nxt;
    part_rem_r   <= part_rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_b_r      <= mul_b_nxt;
    mul_acc_r    <= mul_acc_nxt;
    out_sum_r    <= out_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_divisor_sum = out_sum_r;

endmodule

[rtl/divisor_sum_by_factorization_top.sv]
// Divisor-sum (sigma function) block, top level.
// Depends on dsf_pkg; instantiates dsf_ctrl and dsf_datapath.
//
// Each request carries one unsigned value; the block returns one result with
// the sum of all positive divisors of that value, modulo 2^35. Values 0 and 1
// give 1, a prime p gives p + 1. The value is factored by trial division with
// candidates 2, 3, 4, ... while candidate squared does not exceed the part
// still left to factor. One bit-serial restoring divider does all division:
// after a load step it steps once per dividend bit to produce quotient and
// remainder, and both the loop test and the divisibility test come from the
// same division. Every candidate tried goes through load, steps, evaluate and
// advance. Every extra factor of a prime power goes through load, steps,
// evaluate and a step to extend the power sum. Every distinct prime then also
// passes through the shift-add multiplier, stepping over each bit of the power
// sum and then storing. For a large prime near 2^32 the divider tries every
// candidate up to 65535. A new request is taken only when the previous one is
// finished; the result sits in an output register, so the next request is
// taken even while that result still waits to be read.
module divisor_sum_by_factorization_top import dsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_WIDTH-1:0]   out_divisor_sum
);

  dsf_cmd_t    cmd;
  dsf_status_t status;

  // sequence the factoring loop
  dsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hold the factor state, divide, multiply and hold the result
  dsf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_divisor_sum (out_divisor_sum)
  );

endmodule
